/* rtl/iclp_pkg.sv */
// ============================================================================
// iclp_pkg
// shared types and constants of the indented command line parser
// ============================================================================
`default_nettype none

package iclp_pkg;

    localparam int unsigned MAX_TEXT_LENGTH_DEF = 32'd65536;
    localparam int unsigned MAX_INDENT_DEF      = 32'd255;

    // result queue of the back end
    localparam int unsigned OQ_DEPTH = 4;
    localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);
    localparam int unsigned OQ_CW    = $clog2(OQ_DEPTH + 1);

    typedef enum logic [2:0] {
        CL_END,
        CL_WS,
        CL_TAB,
        CL_NL,
        CL_COM,
        CL_SEMI,
        CL_IDENT,
        CL_OTHER
    } t_cls;

    typedef enum logic [2:0] {
        EV_CMD        = 3'd0,
        EV_ARG        = 3'd1,
        EV_UNEXPECTED = 3'd2,
        EV_TOO_DEEP   = 3'd3,
        EV_DONE       = 3'd4
    } t_kind;

    typedef struct packed {
        t_cls cls;
        logic first_of_text;
        logic end_of_text;
    } t_qitem;

    typedef struct packed {
        t_kind       event_kind;
        logic [15:0] text_start;
        logic [15:0] text_end;
        logic [15:0] line_number;
        logic [7:0]  indent_level;
        logic [7:0]  expected_indent;
        logic [15:0] column;
        logic        last_of_run;
    } t_event;

endpackage

`default_nettype wire

/* rtl/iclp_in_if.sv */
// ============================================================================
// iclp_in_if
// character channel: one code point per transfer
// ============================================================================
`default_nettype none

interface iclp_in_if;
    logic        valid;
    logic        ready;
    logic [20:0] char_code;
    logic        first_of_text;
    logic        end_of_text;

    modport source (output valid, output char_code, output first_of_text,
                    output end_of_text, input ready);
    modport sink   (input valid, input char_code, input first_of_text,
                    input end_of_text, output ready);
endinterface

`default_nettype wire

/* rtl/iclp_out_if.sv */
// ============================================================================
// iclp_out_if
// event channel: one parser event per transfer
// ============================================================================
`default_nettype none

interface iclp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [15:0] text_start;
    logic [15:0] text_end;
    logic [15:0] line_number;
    logic [7:0]  indent_level;
    logic [7:0]  expected_indent;
    logic [15:0] column;
    logic        last_of_run;

    modport source (output valid, output event_kind, output text_start, output text_end,
                    output line_number, output indent_level, output expected_indent,
                    output column, output last_of_run, input ready);
    modport sink   (input valid, input event_kind, input text_start, input text_end,
                    input line_number, input indent_level, input expected_indent,
                    input column, input last_of_run, output ready);
endinterface

`default_nettype wire

/* rtl/indented_command_line_parser.sv */
// ============================================================================
// indented_command_line_parser
// streaming parser of indented command scripts, one character per transfer
// ============================================================================
// i_chr carries one code point per transfer, with first_of_text to start a
// new script and end_of_text to close it. o_evt carries parser events:
// command begin with its tab indentation, argument, unexpected token, too
// much indentation and done; last_of_run marks the final event of a
// character. An identifier event appears with the character after it or at
// end_of_text. A character is taken every cycle while the class queue has
// room; the front classifies it into a two-entry queue and the back runs one
// lexer and grammar step per cycle on it while the result queue has room for
// two events. A character that yields two events takes two transfers on the
// event port, which is the only limit on sustained rate besides the receiver.
// When o_evt stalls, the four-entry event queue absorbs results and then the
// back, and through the class queue the front, hold i_chr off.
// After a done or error event no events appear until first_of_text is set.
// Reset clears both queues and returns the parser to the start of a script.
// ============================================================================
`default_nettype none

module indented_command_line_parser #(
    parameter int unsigned MAX_TEXT_LENGTH = iclp_pkg::MAX_TEXT_LENGTH_DEF,
    parameter int unsigned MAX_INDENT      = iclp_pkg::MAX_INDENT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    iclp_in_if.sink    i_chr,
    iclp_out_if.source o_evt
);

    logic             s_q_valid;
    logic             s_q_ready;
    iclp_pkg::t_qitem s_q_item;

    iclp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_chr     (i_chr),
        .o_q_valid (s_q_valid),
        .o_q_item  (s_q_item),
        .i_q_ready (s_q_ready)
    );

    iclp_back #(
        .MAX_TEXT_LENGTH (MAX_TEXT_LENGTH),
        .MAX_INDENT      (MAX_INDENT)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (s_q_valid),
        .i_q_item  (s_q_item),
        .o_q_ready (s_q_ready),
        .o_evt     (o_evt)
    );

endmodule

`default_nettype wire

/* rtl/iclp_front.sv */
// ============================================================================
// iclp_front
// accepts characters, classifies them and queues the class for the back end
// ============================================================================
`default_nettype none

module iclp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    iclp_in_if.sink          i_chr,
    output logic             o_q_valid,
    output iclp_pkg::t_qitem o_q_item,
    input  logic             i_q_ready
);

    localparam logic [20:0] CH_NUL   = 21'd0;
    localparam logic [20:0] CH_TAB   = 21'd9;
    localparam logic [20:0] CH_LF    = 21'd10;
    localparam logic [20:0] CH_CR    = 21'd13;
    localparam logic [20:0] CH_SPACE = 21'd32;
    localparam logic [20:0] CH_HASH  = 21'd35;
    localparam logic [20:0] CH_PCT   = 21'd37;
    localparam logic [20:0] CH_0     = 21'd48;
    localparam logic [20:0] CH_9     = 21'd57;
    localparam logic [20:0] CH_SEMI  = 21'd59;
    localparam logic [20:0] CH_UA    = 21'd65;
    localparam logic [20:0] CH_UZ    = 21'd90;
    localparam logic [20:0] CH_USCR  = 21'd95;
    localparam logic [20:0] CH_LA    = 21'd97;
    localparam logic [20:0] CH_LZ    = 21'd122;
    localparam logic [20:0] CH_NBSP  = 21'h0000A0;

    function automatic iclp_pkg::t_cls f_classify(input logic [20:0] c);
        iclp_pkg::t_cls r;
        if (c == CH_NUL) begin
            r = iclp_pkg::CL_END;
        end else if (c == CH_CR || c == CH_SPACE || c == CH_NBSP) begin
            r = iclp_pkg::CL_WS;
        end else if (c == CH_TAB) begin
            r = iclp_pkg::CL_TAB;
        end else if (c == CH_LF) begin
            r = iclp_pkg::CL_NL;
        end else if (c == CH_PCT) begin
            r = iclp_pkg::CL_COM;
        end else if (c == CH_SEMI) begin
            r = iclp_pkg::CL_SEMI;
        end else if (c == CH_HASH || c == CH_USCR
                     || (c >= CH_0 && c <= CH_9)
                     || (c >= CH_UA && c <= CH_UZ)
                     || (c >= CH_LA && c <= CH_LZ)) begin
            r = iclp_pkg::CL_IDENT;
        end else begin
            r = iclp_pkg::CL_OTHER;
        end
        return r;
    endfunction

    iclp_pkg::t_qitem r_q [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             s_push;
    logic             s_pop;
    iclp_pkg::t_qitem s_item;

    assign i_chr.ready = (r_cnt != 2'd2);
    assign s_push      = i_chr.valid && i_chr.ready;
    assign o_q_valid   = (r_cnt != 2'd0);
    assign o_q_item    = r_q[r_rp];
    assign s_pop       = o_q_valid && i_q_ready;

    always_comb begin
        s_item.cls           = f_classify(i_chr.char_code);
        s_item.first_of_text = i_chr.first_of_text;
        s_item.end_of_text   = i_chr.end_of_text;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (s_push) begin
                r_wp <= ~r_wp;
            end
            if (s_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(s_push) - 2'(s_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_q[r_wp] <= s_item;
        end
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("class queue overfilled");
    a_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_push && !s_pop) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("class queue count did not grow on transfer in");
    a_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_pop && !s_push) |=> (r_cnt == $past(r_cnt) - 2'd1))
        else $error("class queue count did not shrink on transfer out");
`endif

endmodule

`default_nettype wire

/* rtl/iclp_back.sv */
// ============================================================================
// iclp_back
// lexer and grammar step per queued character, events into a result queue
// ============================================================================
`default_nettype none

module iclp_back #(
    parameter int unsigned MAX_TEXT_LENGTH = iclp_pkg::MAX_TEXT_LENGTH_DEF,
    parameter int unsigned MAX_INDENT      = iclp_pkg::MAX_INDENT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  iclp_pkg::t_qitem i_q_item,
    output logic             o_q_ready,
    iclp_out_if.source       o_evt
);

    localparam int unsigned OFS_W = $clog2(MAX_TEXT_LENGTH);
    localparam int unsigned IND_W = $clog2(MAX_INDENT + 1);
    localparam logic [OFS_W-1:0] OFS_MAX = OFS_W'(MAX_TEXT_LENGTH - 1);
    localparam logic [IND_W-1:0] IND_MAX = IND_W'(MAX_INDENT);

    typedef enum logic [2:0] {
        G_ROOT, G_LINE, G_IGNORE, G_COMMAND, G_ARGUMENT, G_END, G_ERROR
    } t_gram;

    typedef enum logic [2:0] {
        M_NONE, M_TABS, M_WS, M_SEMI, M_IDENT, M_TRAIL, M_COMMENT
    } t_lex;

    typedef struct packed {
        t_gram            gs;
        t_lex             lm;
        logic [OFS_W-1:0] off;
        logic [15:0]      lc;
        logic [OFS_W-1:0] lb;
        logic [OFS_W-1:0] tb;
        logic [OFS_W-1:0] tf;
        logic [IND_W-1:0] ci;
        logic [IND_W:0]   pp1;
        logic             fin;
    } t_st;

    typedef struct packed {
        t_st              st;
        logic [1:0]       n;
        iclp_pkg::t_event ev0;
        iclp_pkg::t_event ev1;
    } t_ctx;

    function automatic t_st f_reset_st();
        t_st r;
        r.gs  = G_ROOT;
        r.lm  = M_NONE;
        r.off = '0;
        r.lc  = '0;
        r.lb  = '0;
        r.tb  = '0;
        r.tf  = '0;
        r.ci  = '0;
        r.pp1 = '0;
        r.fin = 1'b0;
        return r;
    endfunction

    function automatic logic [OFS_W-1:0] f_sat(input logic [OFS_W-1:0] x);
        return (x < OFS_MAX) ? x + OFS_W'(1) : OFS_MAX;
    endfunction

    function automatic t_ctx f_emit(input t_ctx c, input iclp_pkg::t_kind k);
        t_ctx             r;
        iclp_pkg::t_event e;
        logic [31:0]      col;
        r   = c;
        col = 32'(c.st.tb) - 32'(c.st.lb);
        e.event_kind      = k;
        e.text_start      = 16'(c.st.tb);
        e.text_end        = 16'(c.st.tf);
        e.line_number     = c.st.lc;
        e.indent_level    = 8'(c.st.ci);
        e.expected_indent = (32'(c.st.pp1) > 32'd255) ? 8'hFF : 8'(c.st.pp1);
        e.column          = col[15:0];
        e.last_of_run     = 1'b0;
        if (c.n == 2'd0) begin
            r.ev0 = e;
            r.n   = 2'd1;
        end else if (c.n == 2'd1) begin
            r.ev1 = e;
            r.n   = 2'd2;
        end
        return r;
    endfunction

    function automatic t_ctx f_fail(input t_ctx c, input iclp_pkg::t_kind k);
        t_ctx r;
        r        = f_emit(c, k);
        r.st.fin = 1'b1;
        r.st.gs  = G_ERROR;
        return r;
    endfunction

    function automatic t_ctx f_begin_cmd(input t_ctx c);
        t_ctx r;
        if ({1'b0, c.st.ci} > c.st.pp1) begin
            r = f_fail(c, iclp_pkg::EV_TOO_DEEP);
        end else begin
            r        = c;
            r.st.pp1 = {1'b0, c.st.ci} + (IND_W + 1)'(1);
            r        = f_emit(r, iclp_pkg::EV_CMD);
            r.st.gs  = G_ARGUMENT;
        end
        return r;
    endfunction

    function automatic t_ctx f_feed(input t_ctx c, input iclp_pkg::t_cls tok,
                                    input logic [OFS_W-1:0] start,
                                    input logic [OFS_W-1:0] finish);
        t_ctx  r;
        t_gram s;
        r       = c;
        s       = c.st.gs;
        r.st.tb = start;
        r.st.tf = finish;
        if (tok == iclp_pkg::CL_END) begin
            r        = f_emit(r, iclp_pkg::EV_DONE);
            r.st.fin = 1'b1;
            r.st.gs  = G_END;
        end else if (tok == iclp_pkg::CL_NL || tok == iclp_pkg::CL_COM) begin
            r.st.gs = G_ROOT;
        end else if ((s == G_ROOT || s == G_LINE) && tok == iclp_pkg::CL_WS) begin
            r.st.gs = G_IGNORE;
        end else if (s == G_ROOT && tok == iclp_pkg::CL_TAB) begin
            r.st.gs = G_LINE;
        end else if ((s == G_ROOT || s == G_LINE || s == G_COMMAND)
                     && tok == iclp_pkg::CL_IDENT) begin
            r = f_begin_cmd(r);
        end else if (s == G_IGNORE
                     && (tok == iclp_pkg::CL_WS || tok == iclp_pkg::CL_TAB)) begin
            r.st.gs = G_IGNORE;
        end else if (s == G_ARGUMENT && tok == iclp_pkg::CL_IDENT) begin
            r = f_emit(r, iclp_pkg::EV_ARG);
        end else if (s == G_ARGUMENT && tok == iclp_pkg::CL_SEMI) begin
            r.st.gs = G_COMMAND;
        end else begin
            r = f_fail(r, iclp_pkg::EV_UNEXPECTED);
        end
        return r;
    endfunction

    function automatic t_ctx f_new_line(input t_ctx c);
        t_ctx r;
        r = c;
        if (c.st.lc != 16'hFFFF) begin
            r.st.lc = c.st.lc + 16'd1;
        end
        r.st.lb = f_sat(c.st.off);
        r.st.ci = '0;
        return r;
    endfunction

    // hands the pending token to the grammar, ending at the current offset
    function automatic t_ctx f_flush(input t_ctx c);
        t_ctx r;
        r       = c;
        r.st.lm = M_NONE;
        case (c.st.lm)
            M_TABS:  r = f_feed(r, iclp_pkg::CL_TAB, c.st.tb, c.st.off);
            M_WS:    r = f_feed(r, iclp_pkg::CL_WS, c.st.tb, c.st.off);
            M_SEMI:  r = f_feed(r, iclp_pkg::CL_SEMI, c.st.tb, c.st.off);
            M_IDENT: r = f_feed(r, iclp_pkg::CL_IDENT, c.st.tb, c.st.off);
            default: r.st.lm = M_NONE;
        endcase
        return r;
    endfunction

    t_st                      r_st;
    t_ctx                     n_ctx;
    iclp_pkg::t_event         r_oq [iclp_pkg::OQ_DEPTH];
    logic [iclp_pkg::OQ_AW-1:0] r_wp;
    logic [iclp_pkg::OQ_AW-1:0] r_rp;
    logic [iclp_pkg::OQ_CW-1:0] r_ocnt;
    logic                     s_pop;
    logic [1:0]               s_npush;
    logic                     s_opop;
    iclp_pkg::t_event         s_head;

    assign o_q_ready = (r_ocnt <= iclp_pkg::OQ_CW'(iclp_pkg::OQ_DEPTH - 2));
    assign s_pop     = i_q_valid && o_q_ready;
    assign s_npush   = s_pop ? n_ctx.n : 2'd0;

    always_comb begin
        t_ctx             c;
        logic             taken;
        logic [OFS_W-1:0] here;
        iclp_pkg::t_cls   cls;
        cls    = i_q_item.cls;
        c.st   = i_q_item.first_of_text ? f_reset_st() : r_st;
        c.n    = 2'd0;
        c.ev0  = '0;
        c.ev1  = '0;
        taken  = 1'b0;
        here   = '0;
        if (!c.st.fin) begin
            case (c.st.lm)
                M_TABS: begin
                    if (cls == iclp_pkg::CL_TAB) begin
                        if (c.st.ci < IND_MAX) begin
                            c.st.ci = c.st.ci + IND_W'(1);
                        end
                        taken = 1'b1;
                    end
                end
                M_WS, M_SEMI, M_TRAIL: begin
                    if (cls == iclp_pkg::CL_WS) begin
                        taken = 1'b1;
                    end else if (c.st.lm == M_TRAIL) begin
                        c.st.lm = M_NONE;
                    end
                end
                M_IDENT: begin
                    if (cls == iclp_pkg::CL_IDENT) begin
                        taken = 1'b1;
                    end else begin
                        c = f_flush(c);
                        if (!c.st.fin && cls == iclp_pkg::CL_WS) begin
                            c.st.lm = M_TRAIL;
                            taken   = 1'b1;
                        end
                    end
                end
                M_COMMENT: begin
                    if (cls == iclp_pkg::CL_NL) begin
                        c       = f_new_line(c);
                        c.st.lm = M_NONE;
                        taken   = 1'b1;
                    end else if (cls != iclp_pkg::CL_END) begin
                        taken = 1'b1;
                    end else begin
                        c.st.lm = M_NONE;
                    end
                end
                default: begin
                    taken = 1'b0;
                end
            endcase

            if (!taken && !c.st.fin) begin
                c = f_flush(c);
                if (!c.st.fin) begin
                    here = c.st.off;
                    case (cls)
                        iclp_pkg::CL_TAB: begin
                            c.st.lm = M_TABS;
                            c.st.tb = here;
                            c.st.ci = IND_W'(1);
                        end
                        iclp_pkg::CL_WS: begin
                            c.st.lm = M_WS;
                            c.st.tb = here;
                        end
                        iclp_pkg::CL_SEMI: begin
                            c.st.lm = M_SEMI;
                            c.st.tb = here;
                        end
                        iclp_pkg::CL_IDENT: begin
                            c.st.lm = M_IDENT;
                            c.st.tb = here;
                        end
                        iclp_pkg::CL_NL: begin
                            c = f_feed(c, iclp_pkg::CL_NL, here, f_sat(here));
                            c = f_new_line(c);
                        end
                        iclp_pkg::CL_COM: begin
                            c = f_feed(c, iclp_pkg::CL_COM, f_sat(here), f_sat(here));
                            c.st.lm = M_COMMENT;
                        end
                        iclp_pkg::CL_END: begin
                            c = f_feed(c, iclp_pkg::CL_END, here, here);
                        end
                        default: begin
                            c = f_feed(c, iclp_pkg::CL_OTHER, here, f_sat(here));
                        end
                    endcase
                end
            end

            if (!c.st.fin) begin
                c.st.off = f_sat(c.st.off);
            end

            if (i_q_item.end_of_text && !c.st.fin) begin
                c = f_flush(c);
                if (!c.st.fin) begin
                    c = f_feed(c, iclp_pkg::CL_END, c.st.off, c.st.off);
                end
            end
        end

        if (c.n == 2'd1) begin
            c.ev0.last_of_run = 1'b1;
        end else if (c.n == 2'd2) begin
            c.ev1.last_of_run = 1'b1;
        end
        n_ctx = c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= f_reset_st();
        end else if (s_pop) begin
            r_st <= n_ctx.st;
        end
    end

    // result queue
    assign s_head             = r_oq[r_rp];
    assign o_evt.valid        = (r_ocnt != '0);
    assign s_opop             = o_evt.valid && o_evt.ready;
    assign o_evt.event_kind   = s_head.event_kind;
    assign o_evt.text_start   = s_head.text_start;
    assign o_evt.text_end     = s_head.text_end;
    assign o_evt.line_number  = s_head.line_number;
    assign o_evt.indent_level = s_head.indent_level;
    assign o_evt.expected_indent = s_head.expected_indent;
    assign o_evt.column       = s_head.column;
    assign o_evt.last_of_run  = s_head.last_of_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_ocnt <= '0;
        end else begin
            r_wp   <= r_wp + iclp_pkg::OQ_AW'(s_npush);
            r_rp   <= r_rp + iclp_pkg::OQ_AW'(s_opop);
            r_ocnt <= r_ocnt + iclp_pkg::OQ_CW'(s_npush) - iclp_pkg::OQ_CW'(s_opop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_npush != 2'd0) begin
            r_oq[r_wp] <= n_ctx.ev0;
        end
        if (s_npush == 2'd2) begin
            r_oq[r_wp + iclp_pkg::OQ_AW'(1)] <= n_ctx.ev1;
        end
    end

`ifndef SYNTH
    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= iclp_pkg::OQ_CW'(iclp_pkg::OQ_DEPTH))
        else $error("result queue overfilled");
    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_pop && n_ctx.n == 2'd2) |-> (n_ctx.ev1.last_of_run && !n_ctx.ev0.last_of_run))
        else $error("last_of_run misplaced on a pair of events");
    a_quiet_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_pop && r_st.fin && !i_q_item.first_of_text) |-> (n_ctx.n == 2'd0))
        else $error("event issued after the final event");
    a_indent_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_st.pp1) <= 32'(MAX_INDENT) + 32'd1)
        else $error("command indentation out of range");
`endif

endmodule

`default_nettype wire
